// File: rtl/sprf_pkg.sv
// Package with the beat types, fixed-point constants and rounding helpers of the spinor simulator.
`timescale 1ns / 1ps

package sprf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SPINOR_BITS  = 24;
    localparam int FRAC_BITS    = SPINOR_BITS - 2;
    localparam int CORDIC_LAST  = ((CORDIC_STEPS < 24) ? CORDIC_STEPS : 24) - 1;

    localparam int A_W   = (SPINOR_BITS > 22) ? SPINOR_BITS : 22;
    localparam int B_W   = 34;
    localparam int P_W   = A_W + B_W;
    localparam int T_W   = P_W + 2;
    localparam int OM_W  = 23;
    localparam int PHI_W = 23;
    localparam int SQ_W  = 45;
    localparam int D_W   = P_W + 1;
    localparam int Q_W   = 34;
    localparam int SUM_W = SPINOR_BITS + 4;
    localparam int Z_W   = 28;
    localparam int ANG_W = PHI_W + 11;
    localparam int MC_W  = $clog2(A_W);
    localparam int DC_W  = $clog2(D_W);

    localparam logic [0:0] REG_POS_X = 1'b0;
    localparam logic [0:0] REG_POS_Y = 1'b1;

    localparam logic [ANG_W-1:0]    TWO_PI_Q24  = ANG_W'(105414357);
    localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(52707179);
    localparam logic signed [Z_W-1:0] TWO_PI_Z  = Z_W'(105414357);
    localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(26353589);
    localparam logic signed [B_W-1:0] GAIN_Q30  = B_W'(652032874);

    localparam logic [Z_W-1:0] ATAN_Q24 [24] = '{
        Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
        Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069),
        Z_W'(65536),    Z_W'(32768),   Z_W'(16384),   Z_W'(8192),
        Z_W'(4096),     Z_W'(2048),    Z_W'(1024),    Z_W'(512),
        Z_W'(256),      Z_W'(128),     Z_W'(64),      Z_W'(32),
        Z_W'(16),       Z_W'(8),       Z_W'(4),       Z_W'(2)
    };

    typedef struct packed {
        logic signed [15:0] rf_re;
        logic signed [15:0] rf_im;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } t_out_item;

    function automatic logic signed [63:0] f_rsr(input logic signed [63:0] v,
                                                 input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        if (sh != 0) begin
            m = (m + (64'd1 << (sh - 1))) >> sh;
        end
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] f_sat(input logic signed [63:0] v,
                                                 input int unsigned w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = $signed((64'd1 << (w - 1)) - 64'd1);
        lo = -hi - 64'sd1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic logic signed [SPINOR_BITS-1:0] f_to_spinor(input logic signed [63:0] v);
        return SPINOR_BITS'(f_sat(f_rsr(v, 30 - FRAC_BITS), SPINOR_BITS));
    endfunction

    function automatic logic signed [15:0] f_out16(input logic signed [63:0] v);
        return 16'(f_sat(f_rsr(v, FRAC_BITS - 14), 16));
    endfunction

endpackage

// File: rtl/spinor_rf_pulse_simulator.sv
// Spinor RF pulse simulator: one hard-pulse Cayley-Klein rotation per input beat.
`timescale 1ns / 1ps

// Each input beat occupies the block, with o_in_stall high while it is worked on; the angle,
// CORDIC and division steps are skipped when the rotation angle is zero. The time is set by
// the one-bit-per-cycle shift-and-add multiplier, used 24 times per beat (21 when the angle is
// zero), 16 of them with further set-up and accumulation states, and by the one-bit-per-cycle
// divider, used three times; the square root, angle reduction and a 16-step CORDIC add to it. A
// beat marked last produces one result beat, held in an output register; while an earlier
// result beat still waits there under stall, the last beat waits too and the input stays stalled.
module spinor_rf_pulse_simulator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_in_valid,
    input  sprf_pkg::t_in_item    i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output sprf_pkg::t_out_item   o_out_data,
    input  logic                  i_out_stall
);
    import sprf_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MUL   = 5'd1;
    localparam logic [4:0] S_OM1   = 5'd2;
    localparam logic [4:0] S_OM2   = 5'd3;
    localparam logic [4:0] S_SQ1   = 5'd4;
    localparam logic [4:0] S_SQ2   = 5'd5;
    localparam logic [4:0] S_SQ3   = 5'd6;
    localparam logic [4:0] S_SQRT  = 5'd7;
    localparam logic [4:0] S_MOD   = 5'd8;
    localparam logic [4:0] S_FOLD  = 5'd9;
    localparam logic [4:0] S_CORD  = 5'd10;
    localparam logic [4:0] S_SC    = 5'd11;
    localparam logic [4:0] S_DIVM  = 5'd12;
    localparam logic [4:0] S_DIV   = 5'd13;
    localparam logic [4:0] S_DIVD  = 5'd14;
    localparam logic [4:0] S_CM    = 5'd15;
    localparam logic [4:0] S_CMACC = 5'd16;
    localparam logic [4:0] S_UPD   = 5'd17;

    localparam logic [1:0] DSEL_AI = 2'd0;
    localparam logic [1:0] DSEL_BR = 2'd1;
    localparam logic [1:0] DSEL_BI = 2'd2;

    localparam logic signed [SPINOR_BITS-1:0] SPIN_ONE = SPINOR_BITS'(1) <<< FRAC_BITS;

    logic [4:0] r_state;
    logic [4:0] r_ret;
    logic signed [15:0] r_pos_x;
    logic signed [15:0] r_pos_y;
    t_in_item r_in;
    logic signed [SPINOR_BITS-1:0] r_al_re, r_al_im, r_be_re, r_be_im;
    logic signed [SPINOR_BITS-1:0] r_st_ar, r_st_ai, r_st_br, r_st_bi;
    logic signed [OM_W-1:0] r_om;
    logic signed [T_W-1:0] r_t;
    logic [PHI_W-1:0] r_phi;
    logic [SQ_W-1:0] r_v, r_r, r_bit;
    logic [ANG_W-1:0] r_ang;
    logic [3:0] r_k;
    logic signed [B_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0] r_z;
    logic r_flip;
    logic [4:0] r_ci;
    logic [D_W-1:0] r_dn;
    logic [PHI_W-1:0] r_rem;
    logic [Q_W-1:0] r_q;
    logic r_dneg;
    logic [1:0] r_dsel;
    logic [DC_W-1:0] r_dcnt;
    logic [A_W-1:0] r_ma;
    logic [P_W-1:0] r_mb, r_acc;
    logic r_mneg;
    logic [MC_W-1:0] r_mcnt;
    logic signed [SUM_W-1:0] r_sum_ar, r_sum_ai, r_sum_br, r_sum_bi;
    logic r_ovalid;
    t_out_item r_out;

    logic signed [P_W:0] w_prod;
    logic signed [A_W:0] m_a;
    logic signed [B_W-1:0] m_b;
    logic m_start;
    logic [4:0] m_ret;
    logic signed [A_W:0] cm_pr, cm_pi;
    logic signed [B_W-1:0] cm_qr, cm_qi;
    logic [SQ_W-1:0] sq_t;
    logic sq_ge;
    logic [PHI_W:0] d_rem2;
    logic d_ge;
    logic signed [Z_W-1:0] f_r, f_z;
    logic f_flip;
    logic signed [B_W-1:0] c_xs, c_ys;
    logic signed [Q_W:0] dq;
    logic signed [SPINOR_BITS-1:0] dterm;
    logic signed [SUM_W-1:0] cm_rr, cm_ri;
    logic signed [SPINOR_BITS-1:0] n_al_re, n_al_im, n_be_re, n_be_im;
    logic [D_W-1:0] n_dn;

    assign w_prod = r_mneg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});

    always_comb begin
        cm_pr = '0;
        cm_pi = '0;
        cm_qr = '0;
        cm_qi = '0;
        case (r_k[3:2])
            2'd0: begin
                cm_pr = (A_W+1)'(r_st_ar);
                cm_pi = (A_W+1)'(r_st_ai);
                cm_qr = B_W'(r_al_re);
                cm_qi = B_W'(r_al_im);
            end
            2'd1: begin
                cm_pr = (A_W+1)'(r_st_br);
                cm_pi = -((A_W+1)'(r_st_bi));
                cm_qr = B_W'(r_be_re);
                cm_qi = B_W'(r_be_im);
            end
            2'd2: begin
                cm_pr = (A_W+1)'(r_st_br);
                cm_pi = (A_W+1)'(r_st_bi);
                cm_qr = B_W'(r_al_re);
                cm_qi = B_W'(r_al_im);
            end
            default: begin
                cm_pr = (A_W+1)'(r_st_ar);
                cm_pi = -((A_W+1)'(r_st_ai));
                cm_qr = B_W'(r_be_re);
                cm_qi = B_W'(r_be_im);
            end
        endcase
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        m_start = 1'b0;
        m_ret = S_IDLE;
        unique case (r_state)
            S_IDLE: begin
                m_a = (A_W+1)'(r_pos_x);
                m_b = B_W'(i_in_data.grad_x);
                m_start = i_in_valid;
                m_ret = S_OM1;
            end
            S_OM1: begin
                m_a = (A_W+1)'(r_pos_y);
                m_b = B_W'(r_in.grad_y);
                m_start = 1'b1;
                m_ret = S_OM2;
            end
            S_OM2: begin
                m_a = (A_W+1)'(r_in.rf_re);
                m_b = B_W'(r_in.rf_re);
                m_start = 1'b1;
                m_ret = S_SQ1;
            end
            S_SQ1: begin
                m_a = (A_W+1)'(r_in.rf_im);
                m_b = B_W'(r_in.rf_im);
                m_start = 1'b1;
                m_ret = S_SQ2;
            end
            S_SQ2: begin
                m_a = (A_W+1)'(r_om);
                m_b = B_W'(r_om);
                m_start = 1'b1;
                m_ret = S_SQ3;
            end
            S_SC: begin
                m_a = (A_W+1)'(r_om);
                m_b = r_y;
                m_start = 1'b1;
                m_ret = S_DIVM;
            end
            S_DIVD: begin
                m_a = (r_dsel == DSEL_AI) ? (A_W+1)'(r_in.rf_im) : (A_W+1)'(r_in.rf_re);
                m_b = r_y;
                m_start = (r_dsel != DSEL_BI);
                m_ret = S_DIVM;
            end
            S_CM: begin
                case (r_k[1:0])
                    2'd0: begin
                        m_a = cm_pr;
                        m_b = cm_qr;
                    end
                    2'd1: begin
                        m_a = cm_pi;
                        m_b = cm_qi;
                    end
                    2'd2: begin
                        m_a = cm_pr;
                        m_b = cm_qi;
                    end
                    default: begin
                        m_a = cm_pi;
                        m_b = cm_qr;
                    end
                endcase
                m_start = 1'b1;
                m_ret = S_CMACC;
            end
            S_MUL, S_SQ3, S_SQRT, S_MOD, S_FOLD, S_CORD, S_DIVM, S_DIV,
            S_CMACC, S_UPD: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sq_t   = r_r + r_bit;
        sq_ge  = (r_v >= sq_t);
        d_rem2 = {r_rem, r_dn[D_W-1]};
        d_ge   = (d_rem2 >= {1'b0, r_phi});
        c_xs   = r_x >>> r_ci;
        c_ys   = r_y >>> r_ci;
        f_r    = $signed(Z_W'(r_ang));
        if (f_r > PI_Z) begin
            f_r = f_r - TWO_PI_Z;
        end
        f_flip = 1'b0;
        f_z    = f_r;
        if (f_r > HALF_PI_Z) begin
            f_z    = PI_Z - f_r;
            f_flip = 1'b1;
        end else if (f_r < -HALF_PI_Z) begin
            f_z    = -PI_Z - f_r;
            f_flip = 1'b1;
        end
        dq    = $signed({1'b0, r_q});
        dterm = f_to_spinor(64'((r_dneg ^ (r_dsel != DSEL_BR)) ? -dq : dq));
        cm_rr = SUM_W'(f_rsr(64'(r_t - T_W'(w_prod)), FRAC_BITS));
        cm_ri = SUM_W'(f_rsr(64'(r_t + T_W'(w_prod)), FRAC_BITS));
        n_al_re = SPINOR_BITS'(f_sat(64'(r_sum_ar), SPINOR_BITS));
        n_al_im = SPINOR_BITS'(f_sat(64'(r_sum_ai), SPINOR_BITS));
        n_be_re = SPINOR_BITS'(f_sat(64'(r_sum_br), SPINOR_BITS));
        n_be_im = SPINOR_BITS'(f_sat(64'(r_sum_bi), SPINOR_BITS));
        n_dn    = (w_prod[P_W] ? D_W'(-w_prod) : D_W'(w_prod)) + D_W'(r_phi >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_al_re  <= SPIN_ONE;
            r_al_im  <= '0;
            r_be_re  <= '0;
            r_be_im  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_POS_X) begin
                    r_pos_x <= $signed(i_cfg_data);
                end else begin
                    r_pos_y <= $signed(i_cfg_data);
                end
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (m_start) begin
                r_ma   <= m_a[A_W] ? A_W'(-m_a) : A_W'(m_a);
                r_mb   <= m_b[B_W-1] ? P_W'($unsigned(-m_b)) : P_W'($unsigned(m_b));
                r_mneg <= m_a[A_W] ^ m_b[B_W-1];
                r_acc  <= '0;
                r_mcnt <= '0;
                r_ret  <= m_ret;
                r_state <= S_MUL;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in <= i_in_data;
                    end
                end
                S_MUL: begin
                    if (r_ma[0]) begin
                        r_acc <= r_acc + r_mb;
                    end
                    r_ma   <= r_ma >> 1;
                    r_mb   <= r_mb << 1;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == MC_W'(A_W - 1)) begin
                        r_state <= r_ret;
                    end
                end
                S_OM1: begin
                    r_t <= T_W'(w_prod);
                end
                S_OM2: begin
                    r_om <= OM_W'(f_rsr(64'(r_t + T_W'(w_prod)), 10));
                end
                S_SQ1: begin
                    r_t <= T_W'(w_prod);
                end
                S_SQ2: begin
                    r_t <= r_t + T_W'(w_prod);
                end
                S_SQ3: begin
                    r_v     <= SQ_W'(r_t + T_W'(w_prod));
                    r_r     <= '0;
                    r_bit   <= SQ_W'(1) << (SQ_W - 1 - ((SQ_W - 1) % 2));
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_v <= r_v - sq_t;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_phi <= PHI_W'(sq_ge ? (r_r >> 1) + r_bit : r_r >> 1);
                        r_ang <= {PHI_W'(sq_ge ? (r_r >> 1) + r_bit : r_r >> 1), 11'd0};
                        r_k   <= 4'd6;
                        if ((sq_ge ? (r_r >> 1) + r_bit : r_r >> 1) == '0) begin
                            r_st_ar  <= SPIN_ONE;
                            r_st_ai  <= '0;
                            r_st_br  <= '0;
                            r_st_bi  <= '0;
                            r_k      <= '0;
                            r_sum_ar <= '0;
                            r_sum_ai <= '0;
                            r_sum_br <= '0;
                            r_sum_bi <= '0;
                            r_state  <= S_CM;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (r_ang >= (TWO_PI_Q24 << r_k[2:0])) begin
                        r_ang <= r_ang - (TWO_PI_Q24 << r_k[2:0]);
                    end
                    r_k <= r_k - 1'b1;
                    if (r_k == '0) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_z     <= f_z;
                    r_flip  <= f_flip;
                    r_x     <= GAIN_Q30;
                    r_y     <= '0;
                    r_ci    <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_z[Z_W-1]) begin
                        r_x <= r_x - c_ys;
                        r_y <= r_y + c_xs;
                        r_z <= r_z - $signed(ATAN_Q24[r_ci]);
                    end else begin
                        r_x <= r_x + c_ys;
                        r_y <= r_y - c_xs;
                        r_z <= r_z + $signed(ATAN_Q24[r_ci]);
                    end
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == 5'(CORDIC_LAST)) begin
                        r_state <= S_SC;
                    end
                end
                S_SC: begin
                    r_st_ar <= f_to_spinor(64'(r_flip ? -r_x : r_x));
                    r_dsel  <= DSEL_AI;
                end
                S_DIVM: begin
                    r_dn    <= n_dn;
                    r_dneg  <= w_prod[P_W];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= d_ge ? PHI_W'(d_rem2 - {1'b0, r_phi}) : PHI_W'(d_rem2);
                    r_q    <= {r_q[Q_W-2:0], d_ge};
                    r_dn   <= r_dn << 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DC_W'(D_W - 1)) begin
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    case (r_dsel)
                        DSEL_AI: r_st_ai <= dterm;
                        DSEL_BR: r_st_br <= dterm;
                        default: r_st_bi <= dterm;
                    endcase
                    if (r_dsel == DSEL_BI) begin
                        r_k      <= '0;
                        r_sum_ar <= '0;
                        r_sum_ai <= '0;
                        r_sum_br <= '0;
                        r_sum_bi <= '0;
                        r_state  <= S_CM;
                    end else begin
                        r_dsel <= r_dsel + 1'b1;
                    end
                end
                S_CM: begin
                end
                S_CMACC: begin
                    case (r_k[1:0])
                        2'd1: begin
                            case (r_k[3:2])
                                2'd0: r_sum_ar <= r_sum_ar + cm_rr;
                                2'd1: r_sum_ar <= r_sum_ar - cm_rr;
                                default: r_sum_br <= r_sum_br + cm_rr;
                            endcase
                        end
                        2'd3: begin
                            case (r_k[3:2])
                                2'd0: r_sum_ai <= r_sum_ai + cm_ri;
                                2'd1: r_sum_ai <= r_sum_ai - cm_ri;
                                default: r_sum_bi <= r_sum_bi + cm_ri;
                            endcase
                        end
                        default: r_t <= T_W'(w_prod);
                    endcase
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == 4'd15) ? S_UPD : S_CM;
                end
                S_UPD: begin
                    if (!r_in.last) begin
                        r_al_re <= n_al_re;
                        r_al_im <= n_al_im;
                        r_be_re <= n_be_re;
                        r_be_im <= n_be_im;
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || !i_out_stall) begin
                        r_out.a_re <= f_out16(64'(n_al_re));
                        r_out.a_im <= f_out16(64'(n_al_im));
                        r_out.b_re <= f_out16(64'(n_be_re));
                        r_out.b_im <= f_out16(64'(n_be_im));
                        r_ovalid   <= 1'b1;
                        r_al_re    <= SPIN_ONE;
                        r_al_im    <= '0;
                        r_be_re    <= '0;
                        r_be_im    <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/sprf_checker.sv
// Port-level checker for the spinor simulator, bound to the top level.
`timescale 1ns / 1ps

module sprf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input sprf_pkg::t_out_item   o_out_data,
    input logic                  i_out_stall
);
    import sprf_pkg::*;

    // An accepted beat keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in succession");

    // A new result appears only as the block finishes a beat.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat without work in progress");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

endmodule

bind spinor_rf_pulse_simulator sprf_checker u_sprf_checker (.*);

// File: tb/spinor_rf_pulse_simulator_tb.sv
// Self-checking testbench of the spinor RF pulse simulator with a bit-exact spinor predictor.
`timescale 1ns / 1ps

module spinor_rf_pulse_simulator_tb;
    import sprf_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int SETTLE_CYCLES  = 1200;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = REG_POS_X;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        i_out_stall = 1'b0;

    longint    pos_x_q = 0;
    longint    pos_y_q = 0;
    longint    sp_ar, sp_ai, sp_br, sp_bi;
    t_out_item final_spinors [$];
    t_row      typed_rows [$];
    int        errors = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;

    spinor_rf_pulse_simulator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint round_shift(input longint v, input int sh);
        longint m;
        m = (v < 0) ? -v : v;
        if (sh != 0) begin
            m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        end
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint div_nearest(input longint n, input longint d);
        longint m;
        m = (((n < 0) ? -n : n) + d / 2) / d;
        return (n < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic void half_angle_sincos(input longint ang, output longint s,
                                              output longint c);
        longint r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        r = ang % longint'(TWO_PI_Z);
        flip = 1'b0;
        if (r > longint'(PI_Z)) r = r - longint'(TWO_PI_Z);
        if (r > longint'(HALF_PI_Z)) begin
            r = longint'(PI_Z) - r;
            flip = 1'b1;
        end else if (r < -longint'(HALF_PI_Z)) begin
            r = -longint'(PI_Z) - r;
            flip = 1'b1;
        end
        x = longint'(GAIN_Q30);
        y = 0;
        z = r;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(ATAN_Q24[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(ATAN_Q24[i]);
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint q30_to_spinor(input longint v);
        return clamp(round_shift(v, 30 - FRAC_BITS), SPINOR_BITS);
    endfunction

    function automatic void cplx_mul(input longint pr, input longint pim, input longint qr,
                                     input longint qi, output longint rr, output longint ri);
        rr = round_shift(pr * qr - pim * qi, FRAC_BITS);
        ri = round_shift(pr * qi + pim * qr, FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] spinor_to_out(input longint v);
        return 16'(clamp(round_shift(v, FRAC_BITS - 14), 16));
    endfunction

    function automatic void spinor_identity();
        sp_ar = 64'sd1 <<< FRAC_BITS;
        sp_ai = 0;
        sp_br = 0;
        sp_bi = 0;
    endfunction

    // Applies one hard-pulse rotation; returns 1 with the final spinor on a last beat.
    function automatic bit rotate_spinor(input t_in_item it, output t_out_item res);
        longint rre, rim, gx, gy, om, phi, s, c, ar, ai, br, bi;
        longint t1r, t1i, t2r, t2i, nar, nai, nbr, nbi;
        rre = it.rf_re;
        rim = it.rf_im;
        gx = it.grad_x;
        gy = it.grad_y;
        om = round_shift(pos_x_q * gx + pos_y_q * gy, 10);
        phi = int_sqrt(longint'(rre * rre + rim * rim + om * om));
        if (phi == 0) begin
            ar = 64'sd1 <<< FRAC_BITS; ai = 0; br = 0; bi = 0;
        end else begin
            half_angle_sincos(phi <<< 11, s, c);
            ar = q30_to_spinor(c);
            ai = q30_to_spinor(-div_nearest(om * s, phi));
            br = q30_to_spinor(div_nearest(rim * s, phi));
            bi = q30_to_spinor(-div_nearest(rre * s, phi));
        end
        cplx_mul(ar, ai, sp_ar, sp_ai, t1r, t1i);
        cplx_mul(br, -bi, sp_br, sp_bi, t2r, t2i);
        nar = clamp(t1r - t2r, SPINOR_BITS);
        nai = clamp(t1i - t2i, SPINOR_BITS);
        cplx_mul(br, bi, sp_ar, sp_ai, t1r, t1i);
        cplx_mul(ar, -ai, sp_br, sp_bi, t2r, t2i);
        nbr = clamp(t1r + t2r, SPINOR_BITS);
        nbi = clamp(t1i + t2i, SPINOR_BITS);
        sp_ar = nar; sp_ai = nai; sp_br = nbr; sp_bi = nbi;
        res = '0;
        if (!it.last) return 1'b0;
        res.a_re = spinor_to_out(sp_ar);
        res.a_im = spinor_to_out(sp_ai);
        res.b_re = spinor_to_out(sp_br);
        res.b_im = spinor_to_out(sp_bi);
        spinor_identity();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item res;
        t_row      row;
        bit        got;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            got = rotate_spinor(i_in_data, res);
            if (typed_rows.size() != 0) begin
                row = typed_rows.pop_front();
                if (row.typed) res = row.want;
            end
            if (got) final_spinors.push_back(res);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (final_spinors.size() == 0) begin
                report_mismatch("result beat with no expectation");
            end else begin
                res = final_spinors.pop_front();
                if (o_out_data.a_re !== res.a_re)
                    report_mismatch($sformatf("a_re %0d exp %0d", o_out_data.a_re, res.a_re));
                if (o_out_data.a_im !== res.a_im)
                    report_mismatch($sformatf("a_im %0d exp %0d", o_out_data.a_im, res.a_im));
                if (o_out_data.b_re !== res.b_re)
                    report_mismatch($sformatf("b_re %0d exp %0d", o_out_data.b_re, res.b_re));
                if (o_out_data.b_im !== res.b_im)
                    report_mismatch($sformatf("b_im %0d exp %0d", o_out_data.b_im, res.b_im));
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (final_spinors.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_position(input logic [15:0] px, input logic [15:0] py);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_POS_X;
        i_cfg_data <= px;
        @(posedge i_clk);
        i_cfg_idx <= REG_POS_Y;
        i_cfg_data <= py;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pos_x_q = longint'($signed(px));
        pos_y_q = longint'($signed(py));
    endtask

    function automatic logic [15:0] rand_rf();
        case ($urandom_range(3))
            0: return 16'($urandom_range(255)) - 16'd128;
            1: return 16'($urandom_range(8191)) - 16'd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int beats);
        t_in_item it;
        int       len;
        int       n;
        n = 0;
        while (n < beats) begin
            len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
                it.rf_re = rand_rf();
                it.rf_im = rand_rf();
                it.grad_x = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
                it.grad_y = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
                it.last = ($urandom_range(9) == 0) ? 1'($urandom) : (k == len - 1);
                send_beat(it);
                n++;
            end
        end
    endtask

    t_row directed [$];

    function automatic t_row mk(input logic [15:0] re, input logic [15:0] im,
                                input logic [15:0] gx, input logic [15:0] gy,
                                input logic lst, input bit typed);
        t_row r;
        r.it = '{re, im, gx, gy, lst};
        r.typed = typed;
        r.want = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        return r;
    endfunction

    initial begin
        spinor_identity();
        directed.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1));
        directed.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
        directed.push_back(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1));
        directed.push_back(mk(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
        directed.push_back(mk(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
        directed.push_back(mk(16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1, 1'b0));
        directed.push_back(mk(16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 1'b1, 1'b0));
        directed.push_back(mk(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0));
        directed.push_back(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0));
        directed.push_back(mk(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, 1'b0));
        directed.push_back(mk(16'h1922, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
        directed.push_back(mk(16'h1922, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
        directed.push_back(mk(16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 1'b1, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) write_position(16'h8000, 16'h7FFF);
            foreach (directed[i]) begin
                typed_rows.push_back(directed[i]);
                send_beat(directed[i].it);
            end
            drain_and_settle();
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                case ($urandom_range(3))
                    0: write_position(16'h7FFF, 16'h8000);
                    1: write_position(16'($urandom), 16'h0000);
                    default: write_position(16'($urandom), 16'($urandom));
                endcase
                random_phase(60);
                drain_and_settle();
            end
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
